FILE: hw/rtl/veia_pkg.sv
// shared types, operation codes and helpers of the vector element integer alu
`default_nettype none
package veia_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [5:0] DIV_STEPS = 6'd32;

    // configuration register indexes
    localparam logic REG_SEW = 1'b0;
    localparam logic REG_VL  = 1'b1;

    // operand formats
    localparam logic [2:0] FMT_VV  = 3'd0;
    localparam logic [2:0] FMT_MVV = 3'd2;
    localparam logic [2:0] FMT_VI  = 3'd3;
    localparam logic [2:0] FMT_VX  = 3'd4;
    localparam logic [2:0] FMT_MVX = 3'd6;

    // integer class
    localparam logic [5:0] OP_ADD    = 6'h00;
    localparam logic [5:0] OP_SUB    = 6'h02;
    localparam logic [5:0] OP_RSUB   = 6'h03;
    localparam logic [5:0] OP_MINU   = 6'h04;
    localparam logic [5:0] OP_MIN    = 6'h05;
    localparam logic [5:0] OP_MAXU   = 6'h06;
    localparam logic [5:0] OP_MAX    = 6'h07;
    localparam logic [5:0] OP_AND    = 6'h09;
    localparam logic [5:0] OP_OR     = 6'h0A;
    localparam logic [5:0] OP_XOR    = 6'h0B;
    localparam logic [5:0] OP_SEQ    = 6'h10;
    localparam logic [5:0] OP_SNE    = 6'h11;
    localparam logic [5:0] OP_SLTU   = 6'h12;
    localparam logic [5:0] OP_SLT    = 6'h13;
    localparam logic [5:0] OP_SLEU   = 6'h14;
    localparam logic [5:0] OP_SLE    = 6'h15;
    localparam logic [5:0] OP_SGTU   = 6'h16;
    localparam logic [5:0] OP_SGT    = 6'h17;
    localparam logic [5:0] OP_SLL    = 6'h25;
    localparam logic [5:0] OP_SRL    = 6'h26;
    localparam logic [5:0] OP_SRA    = 6'h27;
    localparam logic [5:0] OP_NSRL   = 6'h2C;
    localparam logic [5:0] OP_NSRA   = 6'h2D;
    localparam logic [5:0] OP_WADDU  = 6'h30;
    localparam logic [5:0] OP_WADD   = 6'h31;
    localparam logic [5:0] OP_WSUBU  = 6'h32;
    localparam logic [5:0] OP_WSUB   = 6'h33;
    localparam logic [5:0] OP_WADDUW = 6'h34;
    localparam logic [5:0] OP_WADDW  = 6'h35;
    localparam logic [5:0] OP_WSUBUW = 6'h36;
    localparam logic [5:0] OP_WSUBW  = 6'h37;

    // multiply class
    localparam logic [5:0] OP_MUL    = 6'h08;
    localparam logic [5:0] OP_MULH   = 6'h09;
    localparam logic [5:0] OP_MULHU  = 6'h0A;
    localparam logic [5:0] OP_MULHSU = 6'h0B;
    localparam logic [5:0] OP_DIV    = 6'h0C;
    localparam logic [5:0] OP_DIVU   = 6'h0D;
    localparam logic [5:0] OP_REM    = 6'h0E;
    localparam logic [5:0] OP_REMU   = 6'h0F;
    localparam logic [5:0] OP_MACC   = 6'h20;
    localparam logic [5:0] OP_NMSAC  = 6'h21;
    localparam logic [5:0] OP_MADD   = 6'h22;
    localparam logic [5:0] OP_NMSUB  = 6'h23;

    typedef enum logic [1:0] {
        KIND_OFF,
        KIND_INT,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic        en;
        kind_t       kind;
        logic [5:0]  op;
        logic [1:0]  sew;
        logic [3:0]  bytes;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] d;
    } item_t;

    function automatic logic [31:0] sew_mask(input logic [1:0] sew);
        logic [31:0] m;
        unique case (sew)
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] sext_sew(input logic [31:0] v, input logic [1:0] sew);
        logic [31:0] r;
        unique case (sew)
            2'd0:    r = {{24{v[7]}}, v[7:0]};
            2'd1:    r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] bytes_mask(input logic [3:0] n);
        logic [63:0] m;
        unique case (n)
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/vector_element_integer_alu.sv
// top level of the vector element integer alu
//
// channel   direction  handshake              payload
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// request   in         in_valid/in_ready      req_type .. dest_elem
// result    out        out_valid/out_ready    write_enable, result_value, write_bytes
//
// one request per cycle for all operations but divide and remainder, while the result side is not stalled
// a request is registered in the queue, then in the execute stage and then in the result stage
// divide and remainder hold the execute stage until the divider has finished
// a four-entry queue lets the request side run ahead of a stalled result side
// reset clears the configuration to sew 8 and vector length 0 and empties the queue
`default_nettype none
module vector_element_integer_alu #(
    parameter int VECTOR_BITS = 128
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire [7:0]   cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [5:0]   req_type,
    input  wire [2:0]   op_format,
    input  wire [6:0]   element_index,
    input  wire         unmasked,
    input  wire         mask_bit,
    input  wire [31:0]  vs2_elem,
    input  wire [31:0]  vs1_elem,
    input  wire [31:0]  scalar_value,
    input  wire [4:0]   imm_five,
    input  wire [31:0]  dest_elem,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        write_enable,
    output logic [63:0] result_value,
    output logic [3:0]  write_bytes
);
    import veia_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  q_full;
    logic  head_valid;
    logic  pop;

    assign in_ready = !q_full;

    veia_front #(
        .VECTOR_BITS (VECTOR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .op_format     (op_format),
        .element_index (element_index),
        .unmasked      (unmasked),
        .mask_bit      (mask_bit),
        .vs2_elem      (vs2_elem),
        .vs1_elem      (vs1_elem),
        .scalar_value  (scalar_value),
        .imm_five      (imm_five),
        .dest_elem     (dest_elem),
        .item          (front_item)
    );

    veia_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    veia_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .result_value (result_value),
        .write_bytes  (write_bytes)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/veia_front.sv
// front end: configuration registers, operand selection and request classification
`default_nettype none
module veia_front #(
    parameter int VECTOR_BITS = 128
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_index,
    input  wire [7:0]           cfg_data,
    input  wire [5:0]           req_type,
    input  wire [2:0]           op_format,
    input  wire [6:0]           element_index,
    input  wire                 unmasked,
    input  wire                 mask_bit,
    input  wire [31:0]          vs2_elem,
    input  wire [31:0]          vs1_elem,
    input  wire [31:0]          scalar_value,
    input  wire [4:0]           imm_five,
    input  wire [31:0]          dest_elem,
    output veia_pkg::item_t     item
);
    import veia_pkg::*;

    logic [1:0]  sew_reg;
    logic [7:0]  vl_reg;
    logic        int_fmt;
    logic        mul_fmt;
    logic        enabled;
    logic [31:0] m;
    logic [31:0] b_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sew_reg <= 2'd0;
            vl_reg  <= 8'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SEW)
            begin
                sew_reg <= cfg_data[1:0];
            end
            else
            begin
                vl_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        int_fmt = (op_format == FMT_VV) || (op_format == FMT_VI) || (op_format == FMT_VX);
        mul_fmt = (op_format == FMT_MVV) || (op_format == FMT_MVX);
        enabled = (int_fmt || mul_fmt) && (sew_reg != 2'd3)
                  && ({1'b0, element_index} < vl_reg)
                  && (32'(element_index) < VECTOR_BITS)
                  && (unmasked || mask_bit);
        m = sew_mask(sew_reg);

        if ((op_format == FMT_VV) || (op_format == FMT_MVV))
        begin
            b_raw = vs1_elem;
        end
        else if (op_format == FMT_VI)
        begin
            b_raw = {{27{imm_five[4]}}, imm_five};
        end
        else
        begin
            b_raw = scalar_value;
        end

        item.en   = enabled;
        item.op   = req_type;
        item.sew  = sew_reg;
        item.a    = vs2_elem & m;
        item.b    = b_raw & m;
        item.d    = dest_elem & m;

        if (!enabled)
        begin
            item.kind = KIND_OFF;
        end
        else if (int_fmt)
        begin
            item.kind = KIND_INT;
        end
        else if (req_type[5:2] == 4'h3)
        begin
            item.kind = KIND_DIV;
        end
        else
        begin
            item.kind = KIND_MUL;
        end

        if (!enabled)
        begin
            item.bytes = 4'd1;
        end
        else if (req_type[5:4] == 2'd3)
        begin
            item.bytes = (sew_reg == 2'd0) ? 4'd2 : ((sew_reg == 2'd1) ? 4'd4 : 4'd8);
        end
        else if (req_type[5:2] == 4'hB)
        begin
            item.bytes = (sew_reg == 2'd2) ? 4'd2 : 4'd1;
        end
        else if (req_type[5:3] == 3'd2)
        begin
            item.bytes = 4'd1;
        end
        else
        begin
            item.bytes = (sew_reg == 2'd0) ? 4'd1 : ((sew_reg == 2'd1) ? 4'd2 : 4'd4);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/veia_queue.sv
// short request queue between front and back end
`default_nettype none
module veia_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  veia_pkg::item_t     push_item,
    output logic                full,
    input  wire                 pop,
    output logic                head_valid,
    output veia_pkg::item_t     head_item
);
    import veia_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full       = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/veia_back.sv
// back end: integer alu, multiplier, iterative divider and output stage
`default_nettype none
module veia_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 head_valid,
    input  veia_pkg::item_t     head_item,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic                write_enable,
    output logic [63:0]         result_value,
    output logic [3:0]          write_bytes
);
    import veia_pkg::*;

    typedef struct packed {
        logic        en;
        kind_t       kind;
        logic [5:0]  op;
        logic [1:0]  sew;
        logic [3:0]  bytes;
        logic [31:0] a;
        logic [31:0] d;
        logic [63:0] alu;
        logic [63:0] prod;
    } stage_t;

    item_t       s1_reg;
    logic        s1_valid_reg;
    stage_t      s2_reg;
    stage_t      s2_next;
    logic        s2_valid_reg;

    logic [31:0] dv_rem_reg;
    logic [31:0] dv_quo_reg;
    logic [31:0] dv_den_reg;
    logic [5:0]  dv_cnt_reg;
    logic        dv_neg_reg;

    logic        s1_done;
    logic        s1_adv;
    logic        s2_ready;

    logic [31:0] as1;
    logic [31:0] bs1;
    logic [4:0]  sh;
    logic [31:0] sra_res;
    logic [63:0] int_res;
    logic [32:0] m1;
    logic [32:0] m2;
    logic [65:0] prod_full;
    logic [31:0] div_val;
    logic [31:0] div_res;

    logic [31:0] ha;
    logic [31:0] hb;
    logic        h_signed;
    logic        hnx;
    logic        hny;

    logic [32:0] dv_trial;
    logic [32:0] dv_diff;

    logic [63:0] post;

    assign s1_done  = s1_valid_reg && ((s1_reg.kind != KIND_DIV) || (dv_cnt_reg == DIV_STEPS));
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_done && s2_ready;
    assign pop      = head_valid && (!s1_valid_reg || s1_adv);

    // integer alu
    always_comb
    begin
        as1     = sext_sew(s1_reg.a, s1_reg.sew);
        bs1     = sext_sew(s1_reg.b, s1_reg.sew);
        sh      = s1_reg.b[4:0];
        sra_res = 32'($signed(as1) >>> sh);
        unique case (s1_reg.op)
            OP_ADD:    int_res = {32'd0, s1_reg.a} + {32'd0, s1_reg.b};
            OP_SUB:    int_res = {32'd0, s1_reg.a} - {32'd0, s1_reg.b};
            OP_RSUB:   int_res = {32'd0, s1_reg.b} - {32'd0, s1_reg.a};
            OP_MINU:   int_res = {32'd0, (s1_reg.a < s1_reg.b) ? s1_reg.a : s1_reg.b};
            OP_MIN:    int_res = {32'd0, ($signed(as1) < $signed(bs1)) ? s1_reg.a : s1_reg.b};
            OP_MAXU:   int_res = {32'd0, (s1_reg.a > s1_reg.b) ? s1_reg.a : s1_reg.b};
            OP_MAX:    int_res = {32'd0, ($signed(bs1) < $signed(as1)) ? s1_reg.a : s1_reg.b};
            OP_AND:    int_res = {32'd0, s1_reg.a & s1_reg.b};
            OP_OR:     int_res = {32'd0, s1_reg.a | s1_reg.b};
            OP_XOR:    int_res = {32'd0, s1_reg.a ^ s1_reg.b};
            OP_SEQ:    int_res = {63'd0, s1_reg.a == s1_reg.b};
            OP_SNE:    int_res = {63'd0, s1_reg.a != s1_reg.b};
            OP_SLTU:   int_res = {63'd0, s1_reg.a < s1_reg.b};
            OP_SLT:    int_res = {63'd0, $signed(as1) < $signed(bs1)};
            OP_SLEU:   int_res = {63'd0, s1_reg.a <= s1_reg.b};
            OP_SLE:    int_res = {63'd0, $signed(as1) <= $signed(bs1)};
            OP_SGTU:   int_res = {63'd0, s1_reg.a > s1_reg.b};
            OP_SGT:    int_res = {63'd0, $signed(as1) > $signed(bs1)};
            OP_SLL:    int_res = {32'd0, s1_reg.a} << sh;
            OP_SRL,
            OP_NSRL:   int_res = {32'd0, s1_reg.a >> sh};
            OP_SRA,
            OP_NSRA:   int_res = {{32{sra_res[31]}}, sra_res};
            OP_WADDU,
            OP_WADDUW: int_res = {32'd0, s1_reg.a} + {32'd0, s1_reg.b};
            OP_WADD,
            OP_WADDW:  int_res = {{32{as1[31]}}, as1} + {{32{bs1[31]}}, bs1};
            OP_WSUBU,
            OP_WSUBUW: int_res = {32'd0, s1_reg.a} - {32'd0, s1_reg.b};
            OP_WSUB,
            OP_WSUBW:  int_res = {{32{as1[31]}}, as1} - {{32{bs1[31]}}, bs1};
            default:   int_res = 64'd0;
        endcase
    end

    // multiplier operands and divider result
    always_comb
    begin
        if ((s1_reg.op == OP_MULH) || (s1_reg.op == OP_MULHSU))
        begin
            m1 = {as1[31], as1};
        end
        else if ((s1_reg.op == OP_MADD) || (s1_reg.op == OP_NMSUB))
        begin
            m1 = {1'b0, s1_reg.d};
        end
        else
        begin
            m1 = {1'b0, s1_reg.a};
        end
        m2        = (s1_reg.op == OP_MULH) ? {bs1[31], bs1} : {1'b0, s1_reg.b};
        prod_full = 66'($signed(m1) * $signed(m2));

        div_val = ((s1_reg.op == OP_REM) || (s1_reg.op == OP_REMU)) ? dv_rem_reg : dv_quo_reg;
        if (s1_reg.b == 32'd0)
        begin
            div_res = ((s1_reg.op == OP_DIV) || (s1_reg.op == OP_DIVU))
                      ? sew_mask(s1_reg.sew) : s1_reg.a;
        end
        else
        begin
            div_res = dv_neg_reg ? (32'd0 - div_val) : div_val;
        end

        s2_next.en    = s1_reg.en;
        s2_next.kind  = s1_reg.kind;
        s2_next.op    = s1_reg.op;
        s2_next.sew   = s1_reg.sew;
        s2_next.bytes = s1_reg.bytes;
        s2_next.a     = s1_reg.a;
        s2_next.d     = s1_reg.d;
        s2_next.alu   = (s1_reg.kind == KIND_DIV) ? {32'd0, div_res} : int_res;
        s2_next.prod  = prod_full[63:0];
    end

    // divider setup from the queue head and one restoring step per cycle
    always_comb
    begin
        ha       = sext_sew(head_item.a, head_item.sew);
        hb       = sext_sew(head_item.b, head_item.sew);
        h_signed = (head_item.op == OP_DIV) || (head_item.op == OP_REM);
        hnx      = h_signed && ha[31];
        hny      = h_signed && hb[31];
        dv_trial = {dv_rem_reg, dv_quo_reg[31]};
        dv_diff  = dv_trial - {1'b0, dv_den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dv_cnt_reg   <= 6'd0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
                dv_cnt_reg   <= 6'd0;
            end
            else
            begin
                if (s1_adv)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (s1_valid_reg && (s1_reg.kind == KIND_DIV) && (dv_cnt_reg != DIV_STEPS))
                begin
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                end
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg     <= head_item;
            dv_rem_reg <= 32'd0;
            dv_quo_reg <= hnx ? (32'd0 - ha) : head_item.a;
            dv_den_reg <= hny ? (32'd0 - hb) : head_item.b;
            dv_neg_reg <= (head_item.op == OP_DIV) ? (hnx ^ hny) : hnx;
        end
        else if (s1_valid_reg && (s1_reg.kind == KIND_DIV) && (dv_cnt_reg != DIV_STEPS))
        begin
            if (!dv_diff[32])
            begin
                dv_rem_reg <= dv_diff[31:0];
                dv_quo_reg <= {dv_quo_reg[30:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_trial[31:0];
                dv_quo_reg <= {dv_quo_reg[30:0], 1'b0};
            end
        end
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // result formatting
    always_comb
    begin
        unique case (s2_reg.kind)
            KIND_OFF: post = 64'd0;
            KIND_INT,
            KIND_DIV: post = s2_reg.alu;
            default:
            begin
                unique case (s2_reg.op)
                    OP_MUL:  post = s2_reg.prod;
                    OP_MULH,
                    OP_MULHU,
                    OP_MULHSU:
                    begin
                        unique case (s2_reg.sew)
                            2'd0:    post = s2_reg.prod >> 8;
                            2'd1:    post = s2_reg.prod >> 16;
                            default: post = s2_reg.prod >> 32;
                        endcase
                    end
                    OP_MACC:  post = {32'd0, s2_reg.d} + s2_reg.prod;
                    OP_NMSAC: post = {32'd0, s2_reg.d} - s2_reg.prod;
                    OP_MADD:  post = s2_reg.prod + {32'd0, s2_reg.a};
                    OP_NMSUB: post = {32'd0, s2_reg.a} - s2_reg.prod;
                    default:  post = 64'd0;
                endcase
            end
        endcase
    end

    assign out_valid    = s2_valid_reg;
    assign write_enable = s2_reg.en;
    assign result_value = post & bytes_mask(s2_reg.bytes);
    assign write_bytes  = s2_reg.bytes;

`ifndef SYNTHESIS
    a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_cnt_reg <= DIV_STEPS)
        else $error("divider step count out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_reg))
        else $error("stalled result changed");

    a_off_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_reg.en |-> (s2_reg.bytes == 4'd1) && (s2_reg.kind == KIND_OFF))
        else $error("disabled element with wrong width");
`endif

endmodule
`default_nettype wire
